// ===== src/lap_pkg.sv =====
// Shared types and constants of the four-neighbour Laplacian filter.
package lap_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned DimW      = 11;
  localparam int unsigned PixW      = 8;
  localparam int unsigned LapW      = 11;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [DimW-1:0] MaxWidthDim  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightDim = DimW'(MaxHeight);
  localparam logic [DimW-1:0] WidthReset   = DimW'(640);
  localparam logic [DimW-1:0] HeightReset  = DimW'(480);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1
  } cfg_idx_e;

  // Position of the request at the input, decoded from the counters.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            drain;
    logic            last_col;
    logic            has_above;
    logic            ignore;
  } pos_t;

endpackage

// ===== src/lap_pos_ctrl.sv =====
// Configuration registers and the column and row counters of the filter.
module lap_pos_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [lap_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lap_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        flush_i,
  input  logic                        accept_i,
  output lap_pkg::pos_t               pos_o
);
  import lap_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic [DimW-1:0] width_use;
  logic [DimW-1:0] height_use;
  logic [DimW-1:0] col_next;
  logic            drain;
  logic            last_col;
  logic            ignore;

  // Register writes; the port is always ready.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  width_d  = cfg_data_i;
        CfgImageHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions in use to their legal ranges.
  always_comb begin
    if (width_q == '0) begin
      width_use = DimW'(1);
    end else if (width_q > MaxWidthDim) begin
      width_use = MaxWidthDim;
    end else begin
      width_use = width_q;
    end
    if (height_q == '0) begin
      height_use = DimW'(1);
    end else if (height_q > MaxHeightDim) begin
      height_use = MaxHeightDim;
    end else begin
      height_use = height_q;
    end
  end

  // The last column before the width, or any column past it, ends the row; rows at or past the height drain.
  assign col_next = {{(DimW-ColW){1'b0}}, col_q} + DimW'(1);
  assign last_col = (col_next >= width_use);
  assign drain    = (row_q >= height_use);
  assign ignore   = flush_i && !drain;

  // Counter update for every request that is not dropped.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i && !ignore) begin
      if (last_col) begin
        col_d = '0;
        row_d = drain ? '0 : (row_q + DimW'(1));
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign pos_o.col       = col_q;
  assign pos_o.drain     = drain;
  assign pos_o.last_col  = last_col;
  assign pos_o.has_above = (row_q != '0);
  assign pos_o.ignore    = ignore;

endmodule

// ===== src/lap_line_store.sv =====
// Two line memories holding the rows above, with write-to-read forwarding.
module lap_line_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [lap_pkg::ColW-1:0] rd_col_i,
  input  logic                     wr_en_i,
  input  logic [lap_pkg::ColW-1:0] wr_col_i,
  input  logic [lap_pkg::PixW-1:0] wr_upper_i,
  input  logic [lap_pkg::PixW-1:0] wr_middle_i,
  output logic [lap_pkg::PixW-1:0] up_o,
  output logic [lap_pkg::PixW-1:0] centre_o,
  output logic [lap_pkg::PixW-1:0] right_o,
  output logic [lap_pkg::PixW-1:0] left_o
);
  import lap_pkg::*;

  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];

  logic [ColW-1:0] rd_right_col;
  logic [PixW-1:0] up_rd_q;
  logic [PixW-1:0] centre_rd_q;
  logic [PixW-1:0] right_rd_q;
  logic [PixW-1:0] byp_upper_q;
  logic [PixW-1:0] byp_middle_q;
  logic [PixW-1:0] left_q;
  logic            byp_centre_q, byp_centre_d;
  logic            byp_right_q, byp_right_d;

  assign rd_right_col = rd_col_i + ColW'(1);

  // Upper memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_col_i] <= wr_upper_i;
    end
    if (rd_en_i) begin
      up_rd_q <= upper_mem[rd_col_i];
    end
  end

  // Middle memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      middle_mem[wr_col_i] <= wr_middle_i;
    end
    if (rd_en_i) begin
      centre_rd_q <= middle_mem[rd_col_i];
      right_rd_q  <= middle_mem[rd_right_col];
    end
  end

  // Capture data written in the same cycle as a read of the same column.
  assign byp_centre_d = rd_en_i ? (wr_en_i && (wr_col_i == rd_col_i)) : byp_centre_q;
  assign byp_right_d  = rd_en_i ? (wr_en_i && (wr_col_i == rd_right_col)) : byp_right_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_upper_q  <= wr_upper_i;
      byp_middle_q <= wr_middle_i;
    end
    if (wr_en_i) begin
      left_q <= wr_upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_centre_q <= 1'b0;
      byp_right_q  <= 1'b0;
    end else begin
      byp_centre_q <= byp_centre_d;
      byp_right_q  <= byp_right_d;
    end
  end

  // The left neighbor is the upper value written by the previous column.
  assign up_o     = byp_centre_q ? byp_upper_q : up_rd_q;
  assign centre_o = byp_centre_q ? byp_middle_q : centre_rd_q;
  assign right_o  = byp_right_q ? byp_middle_q : right_rd_q;
  assign left_o   = left_q;

endmodule

// ===== src/laplacian_four_neighbour_filter_core.sv =====
// Top level of the four-neighbour Laplacian filter over a raster pixel stream.
// The request of the pixel below a result passes the input stage register and then the result register.
// Throughput: one request per cycle while the receiver does not hold off the result register.
// The first row of a frame gives no results; width flush requests drain the last row.
// Reset clears the counters, the valid flags and sets width 640 and height 480.
// Line memory contents are not cleared by reset.
module laplacian_four_neighbour_filter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lap_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lap_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lap_pkg::PixW-1:0]    pixel_i,
  input  logic                        flush_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [lap_pkg::LapW-1:0] laplacian_o,
  output logic                        frame_end_o
);
  import lap_pkg::*;

  pos_t            pos;
  logic            accept;
  logic            load;
  logic            fire;
  logic            s1_valid_q, s1_valid_d;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_down_q;
  logic            s1_last_q;
  logic            s1_drain_q;
  logic            s1_emit_q;
  logic            out_valid_q, out_valid_d;
  logic [LapW-1:0] out_lap_q;
  logic            out_end_q;
  logic [PixW-1:0] up;
  logic [PixW-1:0] centre;
  logic [PixW-1:0] right_raw;
  logic [PixW-1:0] left_raw;
  logic [PixW-1:0] right_nb;
  logic [PixW-1:0] left_nb;
  logic [PixW-1:0] wr_upper;
  logic [PixW+1:0] nb_sum;
  logic [PixW+3:0] lap_full;

  assign cfg_ready_o = 1'b1;

  // Handshake: the stage register takes a request when empty or while the previous one moves on.
  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && !pos.ignore;

  lap_pos_ctrl u_pos_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .flush_i     (flush_i),
    .accept_i    (accept),
    .pos_o       (pos)
  );

  // The first row shifts a zero row into the upper line.
  assign wr_upper = s1_emit_q ? centre : '0;

  lap_line_store u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (load),
    .rd_col_i    (pos.col),
    .wr_en_i     (fire),
    .wr_col_i    (s1_col_q),
    .wr_upper_i  (wr_upper),
    .wr_middle_i (s1_down_q),
    .up_o        (up),
    .centre_o    (centre),
    .right_o     (right_raw),
    .left_o      (left_raw)
  );

  // Input stage register.
  assign s1_valid_d = load ? 1'b1 : (fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_col_q   <= pos.col;
      s1_down_q  <= pos.drain ? '0 : pixel_i;
      s1_last_q  <= pos.last_col;
      s1_drain_q <= pos.drain;
      s1_emit_q  <= pos.has_above;
    end
  end

  // Neighbors outside the image read as zero.
  assign left_nb  = (s1_col_q != '0) ? left_raw : '0;
  assign right_nb = s1_last_q ? '0 : right_raw;

  // Kernel: up + down + left + right - 4 * centre.
  assign nb_sum   = {2'b00, up} + {2'b00, s1_down_q} + {2'b00, left_nb} + {2'b00, right_nb};
  assign lap_full = {2'b00, nb_sum} - {2'b00, centre, 2'b00};

  // Result register.
  assign out_valid_d = fire ? s1_emit_q : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_lap_q <= lap_full[LapW-1:0];
      out_end_q <= s1_drain_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign laplacian_o = $signed(out_lap_q);
  assign frame_end_o = out_end_q;

endmodule

// ===== bench/tb_laplacian_four_neighbour_filter_core.sv =====
// Self-checking testbench of the four-neighbour Laplacian filter core.
`timescale 1ns / 1ps

module tb_laplacian_four_neighbour_filter_core;
  import lap_pkg::*;

  // Register writes to index NumCfgRegs and above land on no register.
  localparam int unsigned NumCfgRegs   = 2;
  // Cycles left after the last result before a register write or the end.
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned TailCycles   = 20;
  // Cycles in a row with no request moving on any channel before the run is stopped.
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 110;
  localparam int unsigned MaxPrinted   = 40;

  typedef struct packed {
    logic signed [LapW-1:0] lap;
    logic                   frame_end;
  } lap_result_t;

  typedef enum logic [1:0] {
    ExpModel,
    ExpNone,
    ExpValue
  } exp_mode_e;

  typedef enum logic {
    RowCfg,
    RowItem
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [DimW-1:0]    data;
    logic [PixW-1:0]    pix;
    logic               fl;
    exp_mode_e          mode;
    lap_result_t        want;
  } plan_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgImageWidth;
  logic [DimW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [PixW-1:0]    pixel_i     = '0;
  logic               flush_i     = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [LapW-1:0] laplacian_o;
  logic               frame_end_o;

  // Predictor state: registers, counters and the two line stores.
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  logic [DimW-1:0] col_pos;
  logic [DimW-1:0] row_pos;
  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] mid_mem   [MaxWidth];

  lap_result_t lap_expected [$];
  plan_row_t   plan [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned noise_pct      = 5;
  int unsigned holdoff_req    = 0;
  int unsigned holdoff_left   = 0;
  int unsigned err_count      = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_done    = 0;
  int unsigned cfg_writes     = 0;
  int unsigned stall_count    = 0;

  laplacian_four_neighbour_filter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .flush_i    (flush_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .laplacian_o(laplacian_o),
    .frame_end_o(frame_end_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic flag_mismatch(input string msg);
    if (err_count < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end else if (err_count == MaxPrinted) begin
      $display("[%0t] further mismatches are counted but not shown", $realtime);
    end
    err_count++;
  endtask

  // Out-of-range sizes are pulled into 1..hi.
  function automatic int unsigned dim_used(input logic [DimW-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // One step of the filter: updates the line stores and counters and gives the
  // Laplacian of the pixel one row above, if there is one.
  function automatic void filter_step(input logic [PixW-1:0] pix, input logic fl,
                                      output bit produced, output bit ignored,
                                      output lap_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    bit drain;
    bit last_col;
    int south;
    int north;
    int west;
    int east;
    int centre;
    int lap;
    w = dim_used(width_reg, MaxWidth);
    h = dim_used(height_reg, MaxHeight);
    drain = (row_pos >= h);
    produced = 1'b0;
    ignored = 1'b0;
    res = '0;
    // A flush in the image rows changes nothing.
    if (fl && !drain) begin
      ignored = 1'b1;
      return;
    end
    c = col_pos;
    if (c >= MaxWidth) c = MaxWidth - 1;
    last_col = (c + 1 >= w);
    south = drain ? 0 : int'(pix);
    if (row_pos >= 1) begin
      north  = int'(upper_mem[c]);
      west   = (c > 0) ? int'(upper_mem[c-1]) : 0;
      east   = last_col ? 0 : int'(mid_mem[c+1]);
      centre = int'(mid_mem[c]);
      lap = north + south + west + east - 4 * centre;
      res.lap = LapW'(lap);
      res.frame_end = drain && last_col;
      produced = 1'b1;
    end
    // Shift the column down one row; the first row has a zero row above it.
    upper_mem[c] = (row_pos == '0) ? '0 : mid_mem[c];
    mid_mem[c] = PixW'(south);
    if (last_col) begin
      col_pos = '0;
      row_pos = drain ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = DimW'(c + 1);
    end
  endfunction

  function automatic plan_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [DimW-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = RowCfg;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic [PixW-1:0] pix, input logic fl,
                                         input exp_mode_e mode, input int lap,
                                         input logic fe);
    plan_row_t r;
    r = '0;
    r.kind = RowItem;
    r.pix = pix;
    r.fl = fl;
    r.mode = mode;
    r.want.lap = LapW'(lap);
    r.want.frame_end = fe;
    return r;
  endfunction

  task automatic wait_results();
    while (lap_expected.size() != 0) @(posedge clk_i);
  endtask

  // Register writes go in only while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    in_valid_i <= 1'b0;
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgImageWidth:  width_reg = data;
      CfgImageHeight: height_reg = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Offers one request after a random gap and records what it should give.
  task automatic offer_pixel(input logic [PixW-1:0] pix, input logic fl,
                             input exp_mode_e mode, input lap_result_t typed,
                             output bit ignored);
    bit produced;
    lap_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    pixel_i <= pix;
    flush_i <= fl;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    filter_step(pix, fl, produced, ignored, res);
    case (mode)
      ExpModel: if (produced) lap_expected.push_back(res);
      ExpValue: lap_expected.push_back(typed);
      default: ;
    endcase
  endtask

  // Mostly well-formed requests: pixels in the image rows, flushes in the drain
  // row, with a few flushes and pixels out of place as noise.
  task automatic feed(input int unsigned n, input bit to_frame_end,
                      output int unsigned counted);
    int unsigned h;
    logic [PixW-1:0] pix;
    logic fl;
    bit ignored;
    lap_result_t none;
    counted = 0;
    none = '0;
    while (to_frame_end ? !(counted != 0 && row_pos == '0 && col_pos == '0)
                        : counted < n) begin
      h = dim_used(height_reg, MaxHeight);
      case ($urandom_range(9))
        0: pix = '0;
        1: pix = '1;
        default: pix = PixW'($urandom);
      endcase
      if (row_pos >= h) fl = ($urandom_range(99) >= noise_pct);
      else fl = ($urandom_range(99) < noise_pct);
      offer_pixel(pix, fl, ExpModel, none, ignored);
      if (!ignored) counted++;
    end
  endtask

  // Random register writes between runs of requests. The width only grows at a
  // frame start, so no line store entry is read before it is written.
  task automatic maybe_reconfigure();
    int unsigned pick;
    int unsigned wnow;
    logic [DimW-1:0] val;
    pick = $urandom_range(99);
    wnow = dim_used(width_reg, MaxWidth);
    if (pick < 60) return;
    if (pick < 68) begin
      write_reg(CfgIdxW'($urandom_range(NumCfgRegs, (1 << CfgIdxW) - 1)), DimW'($urandom));
    end else if (pick < 84) begin
      write_reg(CfgImageHeight, DimW'($urandom_range(0, 8)));
    end else if (row_pos == '0 && col_pos == '0) begin
      if ($urandom_range(4) == 0) val = DimW'($urandom_range(25, 48));
      else val = DimW'($urandom_range(0, 24));
      write_reg(CfgImageWidth, val);
    end else begin
      write_reg(CfgImageWidth, DimW'($urandom_range(1, wnow)));
    end
  endtask

  // Result checker and receiver side; a hold-off is counted here.
  always @(posedge clk_i) begin : result_check
    lap_result_t want;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (lap_expected.size() == 0) begin
        flag_mismatch($sformatf("result %0d (laplacian %0d) with nothing expected",
                                results_seen, laplacian_o));
      end else begin
        want = lap_expected.pop_front();
        if (laplacian_o !== want.lap)
          flag_mismatch($sformatf("result %0d laplacian %0d, expected %0d",
                                  results_seen, laplacian_o, want.lap));
        if (frame_end_o !== want.frame_end)
          flag_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                  results_seen, frame_end_o, want.frame_end));
        if (want.frame_end) frames_done++;
      end
      results_seen++;
    end
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("[%0t] no progress for %0d cycles, %0d results outstanding",
               $realtime, StallLimit, lap_expected.size());
      $display("tb_laplacian_four_neighbour_filter_core: FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned ph;
    int unsigned phase_count;
    bit ignored;
    width_reg  = WidthReset;
    height_reg = HeightReset;
    col_pos    = '0;
    row_pos    = '0;

    // Directed table. A 3x3 frame with a cross pattern gives the largest result.
    plan.push_back(cfg_row(CfgImageWidth, DimW'(3)));
    plan.push_back(cfg_row(CfgImageHeight, DimW'(3)));
    plan.push_back(item_row(8'd0, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd255, 1'b0, ExpNone, 0, 1'b0));
    // Flush in an image row is dropped.
    plan.push_back(item_row(8'd0, 1'b1, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd255, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd255, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd255, 1'b0, ExpValue, 1020, 1'b0));
    plan.push_back(item_row(8'd0, 1'b0, ExpModel, 0, 1'b0));
    // A pixel in the drain row counts as a zero pad.
    plan.push_back(item_row(8'd77, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b1, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b1, ExpModel, 0, 1'b0));
    // Zero sizes clamp to a 1x1 frame: a lone bright pixel gives the smallest result.
    plan.push_back(cfg_row(CfgImageWidth, DimW'(0)));
    plan.push_back(cfg_row(CfgImageHeight, DimW'(0)));
    plan.push_back(item_row(8'd255, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b1, ExpValue, -1020, 1'b1));
    // Width cut in mid-row: the column past the new width ends the row.
    plan.push_back(cfg_row(CfgImageWidth, DimW'(3)));
    plan.push_back(cfg_row(CfgImageHeight, DimW'(2)));
    plan.push_back(item_row(8'd10, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd20, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd30, 1'b0, ExpNone, 0, 1'b0));
    plan.push_back(item_row(8'd40, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(cfg_row(CfgImageWidth, DimW'(1)));
    plan.push_back(item_row(8'd50, 1'b0, ExpModel, 0, 1'b0));
    plan.push_back(item_row(8'd0, 1'b1, ExpModel, 0, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) write_reg(plan[i].idx, plan[i].data);
      else offer_pixel(plan[i].pix, plan[i].fl, plan[i].mode, plan[i].want, ignored);
    end

    // Sizes written out of range clamp to the largest frame; a smaller width then
    // ends the first row early and a smaller height starts the drain row mid-row.
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    write_reg(CfgImageWidth, '1);
    write_reg(CfgImageHeight, '1);
    feed(40, 1'b0, counted);
    write_reg(CfgImageWidth, DimW'(12));
    feed(30, 1'b0, counted);
    write_reg(CfgImageHeight, DimW'(2));
    feed(0, 1'b1, counted);

    // Receiver holds off while the sender keeps going, then the sender waits.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CfgImageWidth, DimW'(8));
    write_reg(CfgImageHeight, DimW'(12));
    holdoff_req = HoldCycles;
    feed(0, 1'b1, counted);
    wait_results();
    write_reg(CfgImageHeight, DimW'(4));

    // Random requests in idling phases.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        maybe_reconfigure();
        if ($urandom_range(1) == 0) feed($urandom_range(5, 60), 1'b0, counted);
        else feed(0, 1'b1, counted);
        phase_count += counted;
      end
    end

    in_valid_i <= 1'b0;
    wait_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("Run: %0d pixel and flush requests, %0d results checked, %0d frames ended,",
             items_sent, results_seen, frames_done);
    $display("     %0d register writes, frames from 1x1 up to 48 columns, oversize writes clamped.",
             cfg_writes);
    if (err_count == 0) begin
      $display("tb_laplacian_four_neighbour_filter_core: PASS");
    end else begin
      $display("tb_laplacian_four_neighbour_filter_core: FAIL");
    end
    $finish;
  end

endmodule
